// ===== hdl/huffman_table_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// Huffman table decoder assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_DECODER_ASSERT_SVH
`define HUFFMAN_TABLE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HUFD_ASSERT_SAME(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
    else $error("huffman_table_decoder: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define HUFD_ASSERT_NEXT(label, clock, reset, ante, cons) \
  label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
    else $error("huffman_table_decoder: next-cycle check failed");

`endif

// ===== hdl/hufd_pkg.sv =====
// ----------------------------------------------------------------------------
// Huffman table decoder package
// Sizes, codes and the structs that travel between the top level and cells.
// ----------------------------------------------------------------------------
package hufd_pkg;

  localparam int TABLE_DEPTH  = 128;
  localparam int MAX_CODE_LEN = 9;

  localparam int SYM_W   = 8;
  localparam int CODE_W  = 9;
  localparam int LEN_W   = 4;
  localparam int IDX_W   = 7;
  localparam int COUNT_W = 8;

  localparam int CMP_W     = (MAX_CODE_LEN > CODE_W) ? MAX_CODE_LEN : CODE_W;
  localparam int CNT_W     = $clog2(MAX_CODE_LEN + 1);
  localparam int KEY_LEN_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int LIM_W     = $clog2(TABLE_DEPTH + 1);
  localparam int SEL_W     = (LIM_W > IDX_W) ? LIM_W : IDX_W;

  localparam logic ACT_LOAD   = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  // Search token that walks down the row of cells.
  typedef struct packed {
    logic             active;
    logic             found;
    logic [SYM_W-1:0] symbol;
  } probe_t;

  // Table entry write into one cell.
  typedef struct packed {
    logic              en;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  length;
  } entry_wr_t;

  // Pending code that every cell compares against.
  typedef struct packed {
    logic [CMP_W-1:0]     bits;
    logic [KEY_LEN_W-1:0] length;
  } key_t;

endpackage

// ===== hdl/huffman_table_decoder.sv =====
// ----------------------------------------------------------------------------
// Huffman table decoder
// Prefix code decoder with a loadable code table held in a row of cells.
// ----------------------------------------------------------------------------
// Usage. An item is taken at a rising edge with start high and busy low.
// With action at the load code the item writes entry_symbol, entry_code and
// entry_length into the cell chosen by entry_index; it completes at the
// accepting edge, gives no result, and busy stays low. With action at the
// decode code the item shifts code_bit into the pending code and sends a
// search token down the row of TABLE_DEPTH cells, one cell per cycle. The
// first cell below entry_count whose length and code match claims the token.
// The result, if any, is shown for one cycle on symbol and code_error with
// result_valid high, once the token has passed the launch register and every
// cell; a decode item keeps busy high until the token leaves the last cell,
// so a new item is taken only after the search of the last one is through.
// A decode with no match gives no result unless the pending code has reached
// MAX_CODE_LEN bits, which flags code_error and clears the pending code.
// The receiver cannot stall: each result transfer completes in its cycle.
// entry_count is written through cfg_valid/cfg_ready/cfg_data while idle and
// saturates at TABLE_DEPTH. Reset clears the pending code, entry_count and
// the search; table contents are undefined until loaded.
// ----------------------------------------------------------------------------
`include "huffman_table_decoder_assert.svh"

module huffman_table_decoder (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          action,
  input  logic [hufd_pkg::IDX_W-1:0]    entry_index,
  input  logic [hufd_pkg::SYM_W-1:0]    entry_symbol,
  input  logic [hufd_pkg::CODE_W-1:0]   entry_code,
  input  logic [hufd_pkg::LEN_W-1:0]    entry_length,
  input  logic                          code_bit,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hufd_pkg::COUNT_W-1:0]  cfg_data,
  output logic                          result_valid,
  output logic [hufd_pkg::SYM_W-1:0]    symbol,
  output logic                          code_error
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  logic                                   accept;
  logic                                   accept_load;
  logic                                   accept_decode;
  logic                                   launch;
  logic [hufd_pkg::LIM_W-1:0]             entry_limit;
  logic [hufd_pkg::MAX_CODE_LEN-1:0]      pend_bits;
  logic [hufd_pkg::CNT_W-1:0]             pend_count;
  logic                                   at_max;
  hufd_pkg::key_t                         key;
  hufd_pkg::probe_t                       chain [hufd_pkg::TABLE_DEPTH+1];
  hufd_pkg::probe_t                       last;

  // Items are taken only while no search is running.
  assign busy          = (state != ST_IDLE);
  assign accept        = start && !busy;
  assign accept_load   = accept && (action == hufd_pkg::ACT_LOAD);
  assign accept_decode = accept && (action == hufd_pkg::ACT_DECODE);

  // The configuration register stores the count already clamped to the
  // table depth, so the cells see a ready-made limit.
  assign cfg_ready = !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_limit <= '0;
    end else if (cfg_valid && cfg_ready) begin
      if ({1'b0, cfg_data} > (hufd_pkg::COUNT_W+1)'(hufd_pkg::TABLE_DEPTH)) begin
        entry_limit <= hufd_pkg::LIM_W'(hufd_pkg::TABLE_DEPTH);
      end else begin
        entry_limit <= hufd_pkg::LIM_W'(cfg_data);
      end
    end
  end

  // The token enters the first cell in the cycle after a decode transfer,
  // when the pending code already holds the new bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      launch <= 1'b0;
    end else begin
      launch <= accept_decode;
    end
  end

  assign chain[0] = '{active: launch, found: 1'b0, symbol: '0};
  assign key      = '{bits: hufd_pkg::CMP_W'(pend_bits),
                      length: hufd_pkg::KEY_LEN_W'(pend_count)};

  for (genvar k = 0; k < hufd_pkg::TABLE_DEPTH; k++) begin : g_cell
    hufd_pkg::entry_wr_t wr;
    logic                in_range;

    assign wr.en       = accept_load &&
                         (hufd_pkg::SEL_W'(entry_index) == hufd_pkg::SEL_W'(k));
    assign wr.symbol   = entry_symbol;
    assign wr.code     = entry_code;
    assign wr.length   = entry_length;
    assign in_range    = (hufd_pkg::LIM_W'(k) < entry_limit);

    hufd_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .wr        (wr),
      .in_range  (in_range),
      .key       (key),
      .probe_in  (chain[k]),
      .probe_out (chain[k+1])
    );
  end

  // The token leaving the last cell carries the first match, if any.
  assign last   = chain[hufd_pkg::TABLE_DEPTH];
  assign at_max = (pend_count == hufd_pkg::CNT_W'(hufd_pkg::MAX_CODE_LEN));

  assign result_valid = last.active && (last.found || at_max);
  assign symbol       = last.found ? last.symbol : '0;
  assign code_error   = last.active && !last.found && at_max;

  // Pending code: a decode transfer shifts in the new bit; a result clears it.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_bits  <= '0;
      pend_count <= '0;
    end else begin
      priority if (accept_decode) begin
        pend_bits  <= {pend_bits[hufd_pkg::MAX_CODE_LEN-2:0], code_bit};
        pend_count <= pend_count + hufd_pkg::CNT_W'(1);
      end else if (result_valid) begin
        pend_bits  <= '0;
        pend_count <= '0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept_decode) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (last.active) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // A result only appears at the end of a running search.
  `HUFD_ASSERT_SAME(a_result_in_scan, clk, rst, result_valid, busy)
  // A decode transfer always starts a search.
  `HUFD_ASSERT_NEXT(a_decode_busy, clk, rst, accept_decode, busy)
  // An error result never carries a symbol.
  `HUFD_ASSERT_SAME(a_error_no_symbol, clk, rst, code_error, symbol == '0)
  // Every result leaves the pending code empty.
  `HUFD_ASSERT_NEXT(a_result_clears, clk, rst, result_valid, pend_count == '0)

endmodule

// ===== hdl/hufd_cell.sv =====
// ----------------------------------------------------------------------------
// Huffman table decoder cell
// Holds one code table entry and passes the search token to its neighbor.
// ----------------------------------------------------------------------------
module hufd_cell (
  input  logic               clk,
  input  logic               rst,
  input  hufd_pkg::entry_wr_t wr,
  input  logic               in_range,
  input  hufd_pkg::key_t     key,
  input  hufd_pkg::probe_t   probe_in,
  output hufd_pkg::probe_t   probe_out
);

  logic [hufd_pkg::SYM_W-1:0]  sym;
  logic [hufd_pkg::CODE_W-1:0] code;
  logic [hufd_pkg::LEN_W-1:0]  len;

  logic [hufd_pkg::CMP_W-1:0]  mask;
  logic [hufd_pkg::CMP_W-1:0]  code_masked;
  logic                        hit;

  logic                        p_active;
  logic                        p_found;
  logic [hufd_pkg::SYM_W-1:0]  p_symbol;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      sym  <= wr.symbol;
      code <= wr.code;
      len  <= wr.length;
    end
  end

  // The pending length is never zero during a search, so a length match
  // also rules out empty entries.
  always_comb begin
    mask        = ~({hufd_pkg::CMP_W{1'b1}} << len);
    code_masked = hufd_pkg::CMP_W'(code) & mask;
    hit = probe_in.active && !probe_in.found && in_range &&
          (hufd_pkg::KEY_LEN_W'(len) == key.length) && (code_masked == key.bits);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_active <= 1'b0;
      p_found  <= 1'b0;
    end else begin
      p_active <= probe_in.active;
      p_found  <= probe_in.found | hit;
    end
  end

  always_ff @(posedge clk) begin
    p_symbol <= hit ? sym : probe_in.symbol;
  end

  assign probe_out = '{active: p_active, found: p_found, symbol: p_symbol};

endmodule
